### hdl/f2h_pkg.sv
// ----------------------------------------------------------------------------
// Single-to-half converter package
// Shared constants for the binary32 to binary16 conversion pipeline.
// ----------------------------------------------------------------------------
package f2h_pkg;
  localparam int unsigned SingleWidth = 32;
  localparam int unsigned HalfWidth   = 16;
  localparam logic [14:0] HalfNanMag  = 15'h7FFF;
  localparam logic [14:0] HalfInfMag  = 15'h7C00;
  localparam logic [7:0]  ExpMax      = 8'd255;
  localparam logic [7:0]  ExpOvf      = 8'd142;
  localparam logic [7:0]  ExpNormLo   = 8'd113;
  localparam logic [7:0]  ExpBias     = 8'd112;
  localparam logic [7:0]  SubShiftRef = 8'd126;

  typedef enum logic [1:0] {
    KIND_FINITE = 2'd0,
    KIND_NAN    = 2'd1,
    KIND_INF    = 2'd2,
    KIND_ZERO   = 2'd3
  } kind_t;
endpackage

### hdl/float32_to_float16.sv
// ----------------------------------------------------------------------------
// Single-to-half precision converter
// Converts IEEE 754 binary32 words to binary16, round to nearest, ties away.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, single_bits) takes one binary32
//   word per transfer; the output channel (out_valid, out_stall, half_bits)
//   gives one binary16 word per input, in order.
//   There are three register stages. An accepted word moves from the stage 1
//   register to stage 2 and then to stage 3, whose register drives half_bits
//   and out_valid. Throughput is one word per cycle while out_stall is low:
//   a new word may enter every cycle unless in_stall is high.
//   Stage 1 classifies the word and works out the shift, stage 2 aligns the
//   significand, and stage 3 rounds and packs the result.
//   Reset clears all stage valid bits; data registers are not reset.
//   When the receiver stalls, the output register holds. Each stage moves
//   only if the stage after it is empty or moving, so a full, stalled pipe
//   raises in_stall and no word is lost or repeated.
// ----------------------------------------------------------------------------
module float32_to_float16 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [f2h_pkg::SingleWidth-1:0]    single_bits,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [f2h_pkg::HalfWidth-1:0]      half_bits
);
  import f2h_pkg::*;

  // Stage 1 registers.
  logic        v1;
  logic        s1_sign;
  kind_t       s1_kind;
  logic [23:0] s1_sig;
  logic [6:0]  s1_shift;   // right shift of the significand, 13..125
  logic [4:0]  s1_exp;
  // Stage 2 registers.
  logic        v2;
  logic        s2_sign;
  kind_t       s2_kind;
  logic [9:0]  s2_mag;     // fraction bits after alignment
  logic        s2_rnd;
  logic [4:0]  s2_exp;
  // Stage 3 registers.
  logic        v3;

  logic adv1, adv2, adv3;
  assign adv3     = !v3 || !out_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;
  assign out_valid = v3;

  // Stage 1 decode.
  logic [7:0]  e_in;
  logic [22:0] f_in;
  kind_t       kind_c;
  logic [6:0]  shift_c;
  logic [4:0]  exp_c;
  always_comb begin
    e_in    = single_bits[30:23];
    f_in    = single_bits[22:0];
    shift_c = 7'd13;
    exp_c   = '0;
    if (e_in == ExpMax) begin
      kind_c = (f_in != '0) ? KIND_NAN : KIND_INF;
    end else if (e_in == '0) begin
      kind_c = KIND_ZERO;
    end else if (e_in > ExpOvf) begin
      kind_c = KIND_INF;
    end else begin
      kind_c = KIND_FINITE;
      if (e_in >= ExpNormLo) begin
        exp_c = 5'(e_in - ExpBias);
      end else begin
        shift_c = 7'(SubShiftRef - e_in);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1) begin
      s1_sign  <= single_bits[31];
      s1_kind  <= kind_c;
      s1_sig   <= {1'b1, f_in};
      s1_shift <= shift_c;
      s1_exp   <= exp_c;
    end
  end

  // Stage 2 alignment: shift by k, keep the last bit shifted out for rounding.
  logic [24:0] ext_c;
  logic [24:0] sh_c;
  always_comb begin
    ext_c = {s1_sig, 1'b0};
    sh_c  = (s1_shift < 7'd25) ? (ext_c >> s1_shift) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      s2_sign <= s1_sign;
      s2_kind <= s1_kind;
      s2_mag  <= sh_c[10:1];
      s2_rnd  <= sh_c[0];
      s2_exp  <= s1_exp;
    end
  end

  // Stage 3 rounding and packing; the add lets a carry reach the exponent.
  logic [14:0] mag_c;
  always_comb begin
    unique case (s2_kind)
      KIND_NAN:  mag_c = HalfNanMag;
      KIND_INF:  mag_c = HalfInfMag;
      KIND_ZERO: mag_c = '0;
      default:   mag_c = {s2_exp, s2_mag} + {14'd0, s2_rnd};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      half_bits <= {s2_sign, mag_c};
    end
  end
endmodule
